// ===== design/rwgt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwgt_pkg
// Shared types, widths and codes of the replay window GOP trimmer.
// ----------------------------------------------------------------------------
package rwgt_pkg;

  localparam int unsigned VIDEO_DEPTH_DEF = 4096;
  localparam int unsigned AUDIO_DEPTH_DEF = 4096;
  localparam int unsigned SEG_SLOTS_DEF   = 16;

  localparam int unsigned PTS_W   = 63;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned BYTE_W  = 48;
  localparam int unsigned SEGB_W  = 41;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned CNT_O_W = 13;
  localparam int unsigned FRE_O_W = 5;
  localparam int unsigned CFG_W   = 63;

  localparam logic [SEGB_W-1:0] SEG_BYTES_RESET = SEGB_W'(32 * 1024 * 1024);

  typedef enum logic [1:0] {
    CFG_TIME_WINDOW   = 2'd0,
    CFG_BYTE_BUDGET   = 2'd1,
    CFG_SEGMENT_BYTES = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    KIND_VIDEO = 2'd0,
    KIND_AUDIO = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_VIDEO  = 2'd0,
    OP_AUDIO  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_IGNORED = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOSLOT  = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [PTS_W-1:0] pts;
    logic [SIZE_W-1:0] size;
    logic             key;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    segment_id;
    logic [BYTE_W-1:0]  byte_offset;
    logic [CNT_O_W-1:0] video_entries;
    logic [CNT_O_W-1:0] audio_entries;
    logic [BYTE_W-1:0]  total_bytes;
    logic [CNT_O_W-1:0] evicted_video;
    logic [CNT_O_W-1:0] evicted_audio;
    logic [FRE_O_W-1:0] segments_freed;
    logic [ID_W-1:0]    dropped_gop_count;
  } res_t;

endpackage

// ===== design/rwgt_ram.sv =====
// ----------------------------------------------------------------------------
// rwgt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rwgt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/rwgt_front.sv =====
// ----------------------------------------------------------------------------
// rwgt_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rwgt_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [rwgt_pkg::PTS_W-1:0]  pts_i,
  input  logic [rwgt_pkg::SIZE_W-1:0] payload_size_i,
  input  logic                   is_keyframe_i,
  output logic                   q_valid_o,
  output rwgt_pkg::item_t        q_item_o,
  input  logic                   q_pop_i
);
  import rwgt_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.pts  = pts_i;
    cls.size = payload_size_i;
    cls.key  = is_keyframe_i;
    if (kind_i == KIND_CLEAR) begin
      cls.op = OP_CLEAR;
    end else if (payload_size_i == '0) begin
      cls.op = OP_IGNORE;
    end else if (kind_i == KIND_VIDEO) begin
      cls.op = OP_VIDEO;
    end else if (kind_i == KIND_AUDIO) begin
      cls.op = OP_AUDIO;
    end else begin
      cls.op = OP_IGNORE;
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = q_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/rwgt_back.sv =====
// ----------------------------------------------------------------------------
// rwgt_back
// Sequencer that stores words into the rings and segment table, trims the
// window and delivers one result word per input word.
// ----------------------------------------------------------------------------
module rwgt_back #(
  parameter int unsigned VIDEO_DEPTH = rwgt_pkg::VIDEO_DEPTH_DEF,
  parameter int unsigned AUDIO_DEPTH = rwgt_pkg::AUDIO_DEPTH_DEF,
  parameter int unsigned SEG_SLOTS   = rwgt_pkg::SEG_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [rwgt_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        q_valid_i,
  input  rwgt_pkg::item_t             q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rwgt_pkg::res_t              res_o
);
  import rwgt_pkg::*;

  localparam int unsigned VAW = (VIDEO_DEPTH > 1) ? $clog2(VIDEO_DEPTH) : 1;
  localparam int unsigned AAW = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1;
  localparam int unsigned VCW = $clog2(VIDEO_DEPTH + 1);
  localparam int unsigned ACW = $clog2(AUDIO_DEPTH + 1);
  localparam int unsigned SW  = $clog2(SEG_SLOTS);
  localparam int unsigned SCW = $clog2(SEG_SLOTS + 1);
  localparam int unsigned RCW = $clog2(VIDEO_DEPTH + AUDIO_DEPTH + 1);
  localparam int unsigned VEW = PTS_W + SIZE_W + 1 + SW;
  localparam int unsigned AEW = PTS_W + SIZE_W + SW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SEG   = 10'b00_0000_0010,
    S_STORE = 10'b00_0000_0100,
    S_T0    = 10'b00_0000_1000,
    S_T1    = 10'b00_0001_0000,
    S_VRD   = 10'b00_0010_0000,
    S_VCHK  = 10'b00_0100_0000,
    S_ARD   = 10'b00_1000_0000,
    S_ACHK  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [PTS_W-1:0]  tw_q;
  logic [BYTE_W-1:0] bb_q;
  logic [SEGB_W-1:0] sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= '0;
      bb_q <= '0;
      sb_q <= SEG_BYTES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_TIME_WINDOW:   tw_q <= cfg_data_i[PTS_W-1:0];
        CFG_BYTE_BUDGET:   bb_q <= cfg_data_i[BYTE_W-1:0];
        CFG_SEGMENT_BYTES: sb_q <= cfg_data_i[SEGB_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and working registers.
  item_t             cur_q, cur_d;
  logic [VAW-1:0]    v_head_q, v_head_d;
  logic [VCW-1:0]    v_cnt_q, v_cnt_d;
  logic [AAW-1:0]    a_head_q, a_head_d;
  logic [ACW-1:0]    a_cnt_q, a_cnt_d;
  logic [SEG_SLOTS-1:0] sv_q, sv_d;
  logic [ID_W-1:0]   sid_q [SEG_SLOTS];
  logic [ID_W-1:0]   sid_d [SEG_SLOTS];
  logic [BYTE_W-1:0] sfill_q [SEG_SLOTS];
  logic [BYTE_W-1:0] sfill_d [SEG_SLOTS];
  logic [RCW-1:0]    sref_q [SEG_SLOTS];
  logic [RCW-1:0]    sref_d [SEG_SLOTS];
  logic [SW-1:0]     newest_q, newest_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [BYTE_W-1:0] held_q, held_d;
  logic [ID_W-1:0]   gops_q, gops_d;
  logic              in_gop_q, in_gop_d;
  logic [PTS_W-1:0]  npts_q, npts_d;
  logic [PTS_W-1:0]  floor_q, floor_d;
  status_e           st_q, st_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic [BYTE_W-1:0] roff_q, roff_d;
  logic [VCW-1:0]    ev_v_q, ev_v_d;
  logic [ACW-1:0]    ev_a_q, ev_a_d;
  logic [SCW-1:0]    freed_q, freed_d;
  logic              ov_q, ov_d;
  res_t              res_q, res_d;

  // Rings.
  logic           v_we, a_we;
  logic [VAW-1:0] v_raddr;
  logic [VEW-1:0] v_wdata, v_rdata;
  logic [AEW-1:0] a_wdata, a_rdata;
  logic [VCW:0]   v_sum;
  logic [ACW:0]   a_sum;
  logic [VAW-1:0] v_tail, v_last, v_head_inc;
  logic [AAW-1:0] a_tail, a_head_inc;

  rwgt_ram #(.WIDTH(VEW), .DEPTH(VIDEO_DEPTH), .AW(VAW)) u_vram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_tail),
    .wdata_i(v_wdata),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  rwgt_ram #(.WIDTH(AEW), .DEPTH(AUDIO_DEPTH), .AW(AAW)) u_aram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_tail),
    .wdata_i(a_wdata),
    .raddr_i(a_head_q),
    .rdata_o(a_rdata)
  );

  // Ring address arithmetic.
  always_comb begin
    v_sum = (VCW + 1)'(v_head_q) + (VCW + 1)'(v_cnt_q);
    if (v_sum >= (VCW + 1)'(VIDEO_DEPTH)) begin
      v_sum = v_sum - (VCW + 1)'(VIDEO_DEPTH);
    end
    v_tail = v_sum[VAW-1:0];
    v_last = (v_tail == '0) ? VAW'(VIDEO_DEPTH - 1) : v_tail - VAW'(1);
    v_head_inc = (v_head_q == VAW'(VIDEO_DEPTH - 1)) ? '0 : v_head_q + VAW'(1);
    a_sum = (ACW + 1)'(a_head_q) + (ACW + 1)'(a_cnt_q);
    if (a_sum >= (ACW + 1)'(AUDIO_DEPTH)) begin
      a_sum = a_sum - (ACW + 1)'(AUDIO_DEPTH);
    end
    a_tail = a_sum[AAW-1:0];
    a_head_inc = (a_head_q == AAW'(AUDIO_DEPTH - 1)) ? '0 : a_head_q + AAW'(1);
  end

  // Fields of the ring heads.
  logic [PTS_W-1:0]  vh_pts, ah_pts;
  logic [SIZE_W-1:0] vh_size, ah_size;
  logic              vh_key;
  logic [SW-1:0]     vh_seg, ah_seg;

  assign vh_pts  = v_rdata[VEW-1 -: PTS_W];
  assign vh_size = v_rdata[SW+1 +: SIZE_W];
  assign vh_key  = v_rdata[SW];
  assign vh_seg  = v_rdata[SW-1:0];
  assign ah_pts  = a_rdata[AEW-1 -: PTS_W];
  assign ah_size = a_rdata[SW +: SIZE_W];
  assign ah_seg  = a_rdata[SW-1:0];

  assign v_wdata = {cur_q.pts, cur_q.size, cur_q.key, newest_q};
  assign a_wdata = {cur_q.pts, cur_q.size, newest_q};

  // Segment table read port, and free-slot search.
  logic [SW-1:0]     seg_ra;
  logic              seg_rv;
  logic [BYTE_W-1:0] seg_rfill;
  logic [RCW-1:0]    seg_rref;
  logic              free_found;
  logic [SW-1:0]     free_slot;

  always_comb begin
    if (state_q == S_VCHK) begin
      seg_ra = vh_seg;
    end else if (state_q == S_ACHK) begin
      seg_ra = ah_seg;
    end else begin
      seg_ra = newest_q;
    end
    seg_rv    = ({1'b0, seg_ra} < (SW + 1)'(SEG_SLOTS)) && sv_q[seg_ra];
    seg_rfill = sfill_q[seg_ra];
    seg_rref  = sref_q[seg_ra];
  end

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SEG_SLOTS - 1; i >= 0; i--) begin
      if (!sv_q[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  logic [BYTE_W:0]   fill_sum, held_add;
  logic [SIZE_W-1:0] pop_size;
  logic [RCW-1:0]    ref_dec;
  logic              over;
  logic              need_seg;

  assign fill_sum = {1'b0, seg_rfill} + (BYTE_W + 1)'(cur_q.size);
  assign held_add = {1'b0, held_q} + (BYTE_W + 1)'(cur_q.size);
  assign pop_size = (state_q == S_VCHK) ? vh_size : ah_size;
  assign ref_dec  = (seg_rref != '0) ? seg_rref - RCW'(1) : '0;
  assign over     = ((npts_q > vh_pts) && ((npts_q - vh_pts) > tw_q)) || (held_q > bb_q);
  assign need_seg = !seg_rv ||
                    (({1'b0, seg_rfill} >= (BYTE_W + 1)'(sb_q)) &&
                     (cur_q.op == OP_VIDEO) && cur_q.key);

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    logic pop_v, pop_a;
    state_d   = state_q;
    cur_d     = cur_q;
    v_head_d  = v_head_q;
    v_cnt_d   = v_cnt_q;
    a_head_d  = a_head_q;
    a_cnt_d   = a_cnt_q;
    sv_d      = sv_q;
    sid_d     = sid_q;
    sfill_d   = sfill_q;
    sref_d    = sref_q;
    newest_d  = newest_q;
    next_id_d = next_id_q;
    held_d    = held_q;
    gops_d    = gops_q;
    in_gop_d  = in_gop_q;
    npts_d    = npts_q;
    floor_d   = floor_q;
    st_d      = st_q;
    rid_d     = rid_q;
    roff_d    = roff_q;
    ev_v_d    = ev_v_q;
    ev_a_d    = ev_a_q;
    freed_d   = freed_q;
    ov_d      = ov_q;
    res_d     = res_q;
    v_we      = 1'b0;
    a_we      = 1'b0;
    v_raddr   = v_head_q;
    pop_v     = 1'b0;
    pop_a     = 1'b0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          cur_d   = q_item_i;
          rid_d   = '0;
          roff_d  = '0;
          ev_v_d  = '0;
          ev_a_d  = '0;
          freed_d = '0;
          state_d = S_T0;
          unique case (q_item_i.op)
            OP_CLEAR: begin
              freed_d  = SCW'($countones(sv_q));
              v_head_d = '0;
              v_cnt_d  = '0;
              a_head_d = '0;
              a_cnt_d  = '0;
              sv_d     = '0;
              newest_d = '0;
              held_d   = '0;
              st_d     = ST_CLEARED;
            end
            OP_IGNORE: st_d = ST_IGNORED;
            OP_VIDEO: begin
              if (v_cnt_q >= VCW'(VIDEO_DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                state_d = S_SEG;
              end
            end
            OP_AUDIO: begin
              if (a_cnt_q >= ACW'(AUDIO_DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                state_d = S_SEG;
              end
            end
            default: st_d = ST_IGNORED;
          endcase
        end
      end
      S_SEG: begin
        if (!need_seg) begin
          state_d = S_STORE;
        end else if (!free_found) begin
          st_d    = ST_NOSLOT;
          state_d = S_T0;
        end else begin
          sv_d[free_slot]    = 1'b1;
          sid_d[free_slot]   = next_id_q;
          sfill_d[free_slot] = '0;
          sref_d[free_slot]  = '0;
          newest_d           = free_slot;
          next_id_d          = next_id_q + ID_W'(1);
          state_d            = S_STORE;
        end
      end
      S_STORE: begin
        roff_d            = seg_rfill;
        rid_d             = sid_q[newest_q];
        sfill_d[newest_q] = fill_sum[BYTE_W] ? '1 : fill_sum[BYTE_W-1:0];
        sref_d[newest_q]  = seg_rref + RCW'(1);
        held_d            = held_add[BYTE_W] ? '1 : held_add[BYTE_W-1:0];
        if (cur_q.op == OP_VIDEO) begin
          v_we    = 1'b1;
          v_cnt_d = v_cnt_q + VCW'(1);
        end else begin
          a_we    = 1'b1;
          a_cnt_d = a_cnt_q + ACW'(1);
        end
        st_d    = ST_STORED;
        state_d = S_T0;
      end
      S_T0: begin
        in_gop_d = 1'b0;
        if (v_cnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          v_raddr = v_last;
          state_d = S_T1;
        end
      end
      S_T1: begin
        npts_d  = vh_pts;
        state_d = S_VCHK;
      end
      S_VRD: state_d = S_VCHK;
      S_VCHK: begin
        // Inside a GOP drop, entries go until the next keyframe reaches the head or one entry is left.
        if (in_gop_q) begin
          if ((v_cnt_q > VCW'(1)) && !vh_key) begin
            pop_v = 1'b1;
          end else begin
            gops_d   = gops_q + ID_W'(1);
            in_gop_d = 1'b0;
          end
        end else if ((v_cnt_q > VCW'(1)) && over) begin
          pop_v    = 1'b1;
          in_gop_d = 1'b1;
        end else begin
          floor_d = vh_pts;
          state_d = S_ARD;
        end
        if (pop_v) begin
          v_head_d = v_head_inc;
          v_cnt_d  = v_cnt_q - VCW'(1);
          ev_v_d   = ev_v_q + VCW'(1);
          state_d  = S_VRD;
        end
      end
      S_ARD: state_d = S_ACHK;
      S_ACHK: begin
        if ((a_cnt_q != '0) && (ah_pts < floor_q)) begin
          pop_a    = 1'b1;
          a_head_d = a_head_inc;
          a_cnt_d  = a_cnt_q - ACW'(1);
          ev_a_d   = ev_a_q + ACW'(1);
          state_d  = S_ARD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d                    = 1'b1;
          res_d.status            = st_q;
          res_d.segment_id        = rid_q;
          res_d.byte_offset       = roff_q;
          res_d.video_entries     = CNT_O_W'(v_cnt_q);
          res_d.audio_entries     = CNT_O_W'(a_cnt_q);
          res_d.total_bytes       = held_q;
          res_d.evicted_video     = CNT_O_W'(ev_v_q);
          res_d.evicted_audio     = CNT_O_W'(ev_a_q);
          res_d.segments_freed    = FRE_O_W'(freed_q);
          res_d.dropped_gop_count = gops_q;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A popped entry gives back its bytes and its reference on its segment.
    if (pop_v || pop_a) begin
      held_d = (held_q > BYTE_W'(pop_size)) ? held_q - BYTE_W'(pop_size) : '0;
      if (seg_rv) begin
        sref_d[seg_ra] = ref_dec;
        if ((ref_dec == '0) && (seg_ra != newest_q)) begin
          sv_d[seg_ra] = 1'b0;
          freed_d      = freed_q + SCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    sid_q   <= sid_d;
    sfill_q <= sfill_d;
    sref_q  <= sref_d;
    npts_q  <= npts_d;
    floor_q <= floor_d;
    rid_q   <= rid_d;
    roff_q  <= roff_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      v_head_q  <= '0;
      v_cnt_q   <= '0;
      a_head_q  <= '0;
      a_cnt_q   <= '0;
      sv_q      <= '0;
      newest_q  <= '0;
      next_id_q <= '0;
      held_q    <= '0;
      gops_q    <= '0;
      in_gop_q  <= 1'b0;
      st_q      <= ST_IGNORED;
      ev_v_q    <= '0;
      ev_a_q    <= '0;
      freed_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      v_head_q  <= v_head_d;
      v_cnt_q   <= v_cnt_d;
      a_head_q  <= a_head_d;
      a_cnt_q   <= a_cnt_d;
      sv_q      <= sv_d;
      newest_q  <= newest_d;
      next_id_q <= next_id_d;
      held_q    <= held_d;
      gops_q    <= gops_d;
      in_gop_q  <= in_gop_d;
      st_q      <= st_d;
      ev_v_q    <= ev_v_d;
      ev_a_q    <= ev_a_d;
      freed_q   <= freed_d;
      ov_q      <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_cnt_q <= VCW'(VIDEO_DEPTH))
    else $error("video occupancy above ring depth");

  a_acnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_cnt_q <= ACW'(AUDIO_DEPTH))
    else $error("audio occupancy above ring depth");

  a_store_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STORE) |=> sv_q[newest_q])
    else $error("stored word without a valid newest segment");

  a_trim_keeps_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_VCHK) && (v_cnt_q != '0)) |=> (v_cnt_q != '0))
    else $error("trim emptied the video ring");

endmodule

// ===== design/replay_window_gop_trimmer.sv =====
// ----------------------------------------------------------------------------
// replay_window_gop_trimmer
// Keeps a sliding window of video and audio packet descriptors in segments and
// trims whole GOPs from the video front against a time window and byte budget.
// ----------------------------------------------------------------------------
// One word is worked at a time: it is stored, the video front is trimmed, then
// the audio front, and the result is registered; the trim is skipped when no
// video is held. A queued word is taken in the same cycle as the previous
// result shows. After reset all rings and segments are empty.
module replay_window_gop_trimmer #(
  parameter int unsigned VIDEO_DEPTH = rwgt_pkg::VIDEO_DEPTH_DEF,
  parameter int unsigned AUDIO_DEPTH = rwgt_pkg::AUDIO_DEPTH_DEF,
  parameter int unsigned SEG_SLOTS   = rwgt_pkg::SEG_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [rwgt_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [rwgt_pkg::PTS_W-1:0]    pts_i,
  input  logic [rwgt_pkg::SIZE_W-1:0]   payload_size_i,
  input  logic                          is_keyframe_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [rwgt_pkg::ID_W-1:0]     segment_id_o,
  output logic [rwgt_pkg::BYTE_W-1:0]   byte_offset_o,
  output logic [rwgt_pkg::CNT_O_W-1:0]  video_entries_o,
  output logic [rwgt_pkg::CNT_O_W-1:0]  audio_entries_o,
  output logic [rwgt_pkg::BYTE_W-1:0]   total_bytes_o,
  output logic [rwgt_pkg::CNT_O_W-1:0]  evicted_video_o,
  output logic [rwgt_pkg::CNT_O_W-1:0]  evicted_audio_o,
  output logic [rwgt_pkg::FRE_O_W-1:0]  segments_freed_o,
  output logic [rwgt_pkg::ID_W-1:0]     dropped_gop_count_o
);
  import rwgt_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  rwgt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .pts_i         (pts_i),
    .payload_size_i(payload_size_i),
    .is_keyframe_i (is_keyframe_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  rwgt_back #(
    .VIDEO_DEPTH(VIDEO_DEPTH),
    .AUDIO_DEPTH(AUDIO_DEPTH),
    .SEG_SLOTS  (SEG_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign status_o            = res.status;
  assign segment_id_o        = res.segment_id;
  assign byte_offset_o       = res.byte_offset;
  assign video_entries_o     = res.video_entries;
  assign audio_entries_o     = res.audio_entries;
  assign total_bytes_o       = res.total_bytes;
  assign evicted_video_o     = res.evicted_video;
  assign evicted_audio_o     = res.evicted_audio;
  assign segments_freed_o    = res.segments_freed;
  assign dropped_gop_count_o = res.dropped_gop_count;

endmodule

// ===== tb/sv/replay_window_gop_trimmer_tb.sv =====
// ----------------------------------------------------------------------------
// replay_window_gop_trimmer_tb
// Drives packet, audio and clear words into the trimmer under random idling on
// both sides, predicts every result word from a model of the rings and the
// segment table, and compares each result field by field.
// ----------------------------------------------------------------------------
module replay_window_gop_trimmer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rwgt_pkg::*;

  localparam int VDEPTH = VIDEO_DEPTH_DEF;
  localparam int ADEPTH = AUDIO_DEPTH_DEF;
  localparam int NSLOT  = SEG_SLOTS_DEF;
  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
  localparam int  RAND_WORDS = 1750;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int EXP_DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = '0;
  logic [PTS_W-1:0] pts_i = '0;
  logic [SIZE_W-1:0] payload_size_i = '0;
  logic is_keyframe_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [ID_W-1:0] segment_id_o;
  logic [BYTE_W-1:0] byte_offset_o;
  logic [CNT_O_W-1:0] video_entries_o, audio_entries_o;
  logic [BYTE_W-1:0] total_bytes_o;
  logic [CNT_O_W-1:0] evicted_video_o, evicted_audio_o;
  logic [FRE_O_W-1:0] segments_freed_o;
  logic [ID_W-1:0] dropped_gop_count_o;

  replay_window_gop_trimmer DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state of the window.
  logic [PTS_W-1:0]  v_pts [VDEPTH];
  logic [SIZE_W-1:0] v_size[VDEPTH];
  logic              v_key [VDEPTH];
  int                v_seg [VDEPTH];
  logic [PTS_W-1:0]  a_pts [ADEPTH];
  logic [SIZE_W-1:0] a_size[ADEPTH];
  int                a_seg [ADEPTH];
  int v_head, v_cnt, a_head, a_cnt;
  bit seg_live[NSLOT];
  logic [ID_W-1:0]   seg_id_tab[NSLOT];
  logic [BYTE_W-1:0] seg_fill[NSLOT];
  int seg_refs[NSLOT];
  int newest_slot;
  logic [ID_W-1:0] next_id, gop_drops;
  logic [BYTE_W-1:0] held;
  int freed_now;
  logic [PTS_W-1:0]  win_ticks;
  logic [BYTE_W-1:0] budget;
  logic [SEGB_W-1:0] seg_limit;

  // Predicted result words in send order, as a small circular list.
  res_t exp_mem[EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  longint cycles = 0;

  function automatic logic [BYTE_W-1:0] add_sat(logic [BYTE_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + b;
    return s[BYTE_W] ? BYTE_MAX : s[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] sub_floor(logic [BYTE_W-1:0] a, logic [SIZE_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic void drop_ref(int slot);
    if (!seg_live[slot]) return;
    if (seg_refs[slot] > 0) seg_refs[slot]--;
    if (seg_refs[slot] > 0 || slot == newest_slot) return;
    seg_live[slot] = 0;
    freed_now++;
  endfunction

  function automatic void retire_video_head();
    held = sub_floor(held, v_size[v_head]);
    drop_ref(v_seg[v_head]);
    v_head = (v_head + 1) % VDEPTH;
    v_cnt--;
  endfunction

  function automatic bit window_exceeded(logic [PTS_W-1:0] newest);
    logic [PTS_W-1:0] oldest;
    oldest = v_pts[v_head];
    return (newest > oldest && (newest - oldest) > win_ticks) || held > budget;
  endfunction

  function automatic void clear_window();
    v_head = 0; v_cnt = 0; a_head = 0; a_cnt = 0;
    for (int i = 0; i < NSLOT; i++) begin
      seg_live[i] = 0; seg_fill[i] = '0; seg_refs[i] = 0; seg_id_tab[i] = '0;
    end
    newest_slot = 0;
    held = '0;
  endfunction

  function automatic void write_register(cfg_e idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_TIME_WINDOW:   win_ticks = val;
      CFG_BYTE_BUDGET:   budget = val[BYTE_W-1:0];
      CFG_SEGMENT_BYTES: seg_limit = val[SEGB_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic res_t predict_window(logic [1:0] kind, logic [PTS_W-1:0] pts,
                                          logic [SIZE_W-1:0] size, logic key);
    res_t r;
    int slot, p;
    int ev_v, ev_a;
    bit open_seg;
    logic [PTS_W-1:0] newest, floor_pts;
    r = '0;
    r.status = ST_IGNORED;
    ev_v = 0; ev_a = 0;
    freed_now = 0;
    if (kind == OP_CLEAR) begin
      for (int i = 0; i < NSLOT; i++) if (seg_live[i]) freed_now++;
      clear_window();
      r.status = ST_CLEARED;
    end else if (kind == OP_IGNORE || size == 0) begin
      r.status = ST_IGNORED;
    end else if ((kind == OP_VIDEO && v_cnt >= VDEPTH) ||
                 (kind == OP_AUDIO && a_cnt >= ADEPTH)) begin
      r.status = ST_FULL;
    end else begin
      open_seg = !seg_live[newest_slot] ||
                 (seg_fill[newest_slot] >= BYTE_W'(seg_limit) &&
                  kind == OP_VIDEO && key);
      slot = newest_slot;
      if (open_seg) begin
        slot = NSLOT;
        for (int i = 0; i < NSLOT; i++) if (!seg_live[i]) begin
          slot = i;
          break;
        end
        if (slot < NSLOT) begin
          seg_live[slot] = 1; seg_id_tab[slot] = next_id; next_id++;
          seg_fill[slot] = '0; seg_refs[slot] = 0; newest_slot = slot;
        end
      end
      if (slot == NSLOT) begin
        r.status = ST_NOSLOT;
      end else begin
        r.byte_offset = seg_fill[slot];
        r.segment_id = seg_id_tab[slot];
        seg_fill[slot] = add_sat(seg_fill[slot], size);
        seg_refs[slot]++;
        if (kind == OP_VIDEO) begin
          p = (v_head + v_cnt) % VDEPTH;
          v_pts[p] = pts; v_size[p] = size; v_key[p] = key; v_seg[p] = slot;
          v_cnt++;
        end else begin
          p = (a_head + a_cnt) % ADEPTH;
          a_pts[p] = pts; a_size[p] = size; a_seg[p] = slot;
          a_cnt++;
        end
        held = add_sat(held, size);
        r.status = ST_STORED;
      end
    end
    // Whole GOPs leave the video front, then audio older than the oldest video.
    if (v_cnt > 0) begin
      newest = v_pts[(v_head + v_cnt - 1) % VDEPTH];
      while (v_cnt > 1 && window_exceeded(newest)) begin
        retire_video_head(); ev_v++;
        while (v_cnt > 1 && !v_key[v_head]) begin
          retire_video_head(); ev_v++;
        end
        gop_drops++;
      end
      floor_pts = v_pts[v_head];
      while (a_cnt > 0 && a_pts[a_head] < floor_pts) begin
        held = sub_floor(held, a_size[a_head]);
        drop_ref(a_seg[a_head]);
        a_head = (a_head + 1) % ADEPTH;
        a_cnt--; ev_a++;
      end
    end
    r.video_entries = CNT_O_W'(v_cnt);
    r.audio_entries = CNT_O_W'(a_cnt);
    r.total_bytes = held;
    r.evicted_video = CNT_O_W'(ev_v);
    r.evicted_audio = CNT_O_W'(ev_a);
    r.segments_freed = FRE_O_W'(freed_now);
    r.dropped_gop_count = gop_drops;
    return r;
  endfunction

  // Directed rows; a row with has_exp set also carries a hand-typed result.
  typedef struct {
    logic [1:0] kind;
    logic [PTS_W-1:0] pts;
    logic [SIZE_W-1:0] size;
    logic key;
    bit has_exp;
    res_t exp_word;
  } row_t;

  // Valid stays high after an accept and is dropped only when idling follows,
  // so it never gets two updates in one step.
  task automatic drive_word(logic [1:0] kind, logic [PTS_W-1:0] pts,
                            logic [SIZE_W-1:0] size, logic key);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i <= kind; pts_i <= pts; payload_size_i <= size; is_keyframe_i <= key;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_word(logic [1:0] kind, logic [PTS_W-1:0] pts,
                           logic [SIZE_W-1:0] size, logic key);
    exp_mem[exp_wr % EXP_DEPTH] = predict_window(kind, pts, size, key);
    exp_wr++;
    drive_word(kind, pts, size, key);
  endtask

  task automatic drain_then_config(cfg_e idx, logic [CFG_W-1:0] val);
    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    write_register(idx, val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed streams: rising pts, GOPs opened by keyframes, audio
  // interleaved, with the odd clear, ignored or empty word.
  task automatic random_stream(int count, int unsigned size_span);
    logic [PTS_W-1:0] t;
    int pick;
    logic [SIZE_W-1:0] sz;
    t = PTS_W'({$urandom, $urandom} >> 9);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      sz = $urandom_range(1, size_span);
      if (pick < 2) send_word(OP_CLEAR, PTS_W'({$urandom, $urandom}), $urandom,
                              1'($urandom));
      else if (pick < 4) send_word(OP_IGNORE, PTS_W'({$urandom, $urandom}), $urandom,
                                   1'($urandom));
      else if (pick < 6) send_word(2'($urandom_range(0, 1)), t, 0, 1'($urandom));
      else if (pick < 9) send_word(2'($urandom_range(0, 1)), PTS_W'({$urandom, $urandom}),
                                   $urandom, 1'($urandom));
      else if (pick < 50) begin
        t += $urandom_range(0, 400);
        send_word(OP_VIDEO, t, sz, $urandom_range(0, 4) == 0);
      end else begin
        send_word(OP_AUDIO, t - $urandom_range(0, 300), sz, 1'($urandom));
      end
    end
  endtask

  // Result side: random stall per word, compare with the oldest prediction.
  initial begin
    res_t got, want;
    int hold;
    forever begin
      @(negedge clk_i);
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      got = '{status_e'(status_o), segment_id_o, byte_offset_o, video_entries_o,
              audio_entries_o, total_bytes_o, evicted_video_o, evicted_audio_o,
              segments_freed_o, dropped_gop_count_o};
      if (exp_wr == exp_rd) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[9];
    res_t z;
    win_ticks = '0; budget = '0; seg_limit = SEG_BYTES_RESET;
    next_id = '0; gop_drops = '0;
    clear_window();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Right after reset an empty packet or an unused kind leaves all at zero.
    z = '0; z.status = ST_IGNORED;
    rows[0] = '{OP_VIDEO, '1, 0, 1, 1, z};
    rows[1] = '{OP_IGNORE, '1, '1, 1, 1, z};
    z.status = ST_CLEARED;
    rows[2] = '{OP_CLEAR, 0, 0, 0, 1, z};
    rows[3] = '{OP_VIDEO, 0, '1, 1, 0, z};
    rows[4] = '{OP_AUDIO, 0, '1, 0, 0, z};
    rows[5] = '{OP_VIDEO, '1, 1, 1, 0, z};
    rows[6] = '{OP_VIDEO, 5, 7, 0, 0, z};
    rows[7] = '{OP_AUDIO, 3, 9, 1, 0, z};
    rows[8] = '{OP_CLEAR, '1, '1, 1, 0, z};
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        // Check the typed row against the model too, so both stay in step.
        z = predict_window(rows[i].kind, rows[i].pts, rows[i].size, rows[i].key);
        if (z !== rows[i].exp_word) begin
          errors++;
          if (errors <= 10) $display("table row %0d disagrees with prediction", i);
        end
        exp_mem[exp_wr % EXP_DEPTH] = rows[i].exp_word;
        exp_wr++;
        drive_word(rows[i].kind, rows[i].pts, rows[i].size, rows[i].key);
      end else begin
        send_word(rows[i].kind, rows[i].pts, rows[i].size, rows[i].key);
      end
    end

    // Zero segment size: each keyframe opens a segment, filling the table.
    drain_then_config(CFG_SEGMENT_BYTES, 0);
    drain_then_config(CFG_TIME_WINDOW, '1);
    drain_then_config(CFG_BYTE_BUDGET, BYTE_MAX);
    for (int i = 0; i < 18; i++) send_word(OP_VIDEO, PTS_W'(100 + i), 10, 1);
    send_word(OP_AUDIO, 50, 4, 0);
    send_word(OP_VIDEO, 200, 1, 0);

    // Time window trimming of whole GOPs.
    drain_then_config(CFG_TIME_WINDOW, 1000);
    drain_then_config(CFG_SEGMENT_BYTES, 3000);
    random_stream(500, 400);
    send_word(OP_VIDEO, 10, 5, 1);

    // Byte budget trimming, tiny window, reset segment size.
    drain_then_config(CFG_BYTE_BUDGET, 20000);
    drain_then_config(CFG_TIME_WINDOW, 0);
    drain_then_config(CFG_SEGMENT_BYTES, SEG_BYTES_RESET);
    random_stream(400, 2000);

    // Segment size of 2^40 bytes, largest window, tight budget on large words.
    drain_then_config(CFG_SEGMENT_BYTES, 41'h100_0000_0000);
    drain_then_config(CFG_TIME_WINDOW, '1);
    drain_then_config(CFG_BYTE_BUDGET, 48'h0000_FFFF_FFFF);
    random_stream(400, 32'hFFFF_FFFF);

    // Moderate settings with many small segments.
    drain_then_config(CFG_SEGMENT_BYTES, 1);
    drain_then_config(CFG_BYTE_BUDGET, 5000);
    drain_then_config(CFG_TIME_WINDOW, 3000);
    random_stream(450, 300);

    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rwgt_pkg.sv
design/rwgt_ram.sv
design/rwgt_front.sv
design/rwgt_back.sv
design/replay_window_gop_trimmer.sv
tb/sv/replay_window_gop_trimmer_tb.sv
